// File: src/shkd_pkg.sv
// package for the shake detector: sizes, register indexes, state and axis codes
`default_nettype none

package shkd_pkg;

    localparam int WINDOW      = 20;
    localparam int SAMPLE_BITS = 16;

    // fixed field widths
    localparam int ACCEL_W = 16;
    localparam int TS_W    = 48;
    localparam int THR_W   = 15;
    localparam int MINI_W  = 32;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 1;

    // derived sizes
    localparam int CLOG_N = $clog2(WINDOW);
    localparam int IDX_W  = (CLOG_N < 1) ? 1 : CLOG_N;
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int MAG_W  = SAMPLE_BITS + CLOG_N;
    localparam int SUM_W  = MAG_W + 1;
    localparam int SQ_W   = (MAG_W > THR_W) ? MAG_W : THR_W;
    localparam int PROD_W = 2 * SQ_W;
    localparam int SSQ_W  = 2 * SAMPLE_BITS - 1 + CLOG_N;
    localparam int D_W    = 2 * SAMPLE_BITS - 1 + 2 * CLOG_N;
    localparam int LIM_W  = 2 * THR_W + 2 * CLOG_N;
    localparam int CMP_W  = ((D_W + 2) > LIM_W) ? (D_W + 2) : LIM_W;

    localparam logic [CFG_IDX_W-1:0] REG_SD_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 1'd1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        sample_t x;
        sample_t y;
        sample_t z;
    } triple_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_SQS,
        ST_DIF,
        ST_THR,
        ST_CMP,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        AX_X,
        AX_Y,
        AX_Z
    } axis_t;

    // low SAMPLE_BITS bits of the raw field, read as two's complement
    function automatic sample_t to_sample(input logic [ACCEL_W-1:0] raw);
        logic [ACCEL_W+SAMPLE_BITS-1:0] wide;
        begin
            wide = {{SAMPLE_BITS{1'b0}}, raw};
            return sample_t'(wide[SAMPLE_BITS-1:0]);
        end
    endfunction

endpackage

`default_nettype wire

// File: src/shkd_sample_if.sv
// input channel: one three-axis sample with its timestamp
`default_nettype none

interface shkd_sample_if
    import shkd_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [ACCEL_W-1:0] accel_x;
    logic signed [ACCEL_W-1:0] accel_y;
    logic signed [ACCEL_W-1:0] accel_z;
    logic [TS_W-1:0]           timestamp_us;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    output timestamp_us, input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    input timestamp_us, output ready);
endinterface

`default_nettype wire

// File: src/shkd_result_if.sv
// output channel: shake flags for one sample
`default_nettype none

interface shkd_result_if;
    logic valid;
    logic ready;
    logic shake_event;
    logic shake_too_soon;
    logic window_evaluated;

    modport source (output valid, output shake_event, output shake_too_soon,
                    output window_evaluated, input ready);
    modport sink   (input valid, input shake_event, input shake_too_soon,
                    input window_evaluated, output ready);
endinterface

`default_nettype wire

// File: src/shake_detector_windowed_variance_core.sv
// shake detector: sample windows, shared squarer sequencer and result register
//
//  channel   dir   handshake       payload
//  sample    in    valid/ready     accel_x, accel_y, accel_z, timestamp_us
//  result    out   valid/ready     shake_event, shake_too_soon, window_evaluated
//  cfg       in    cfg_we          cfg_index, cfg_data
//
// a word taken while the windows fill goes straight to the done state; once full
// the single squarer walks each axis window in turn before the word is done. reset
// empties the windows and clears the last shake time, no clearing pass. a finished
// word waits in the result register while the next sample is taken; the sequencer
// only stalls in its last state.
`default_nettype none

module shake_detector_windowed_variance_core
    import shkd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    shkd_sample_if.sink               sample,
    shkd_result_if.source             result,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    state_t state_reg, state_next;

    triple_t             win_reg [WINDOW];
    logic [FILL_W-1:0]   fill_reg;
    logic [IDX_W-1:0]    oldest_reg;
    logic [IDX_W-1:0]    idx_reg;
    axis_t               axis_reg;
    logic [TS_W-1:0]     ts_reg;
    logic [TS_W-1:0]     last_shake_reg;
    logic [THR_W-1:0]    thr_reg;
    logic [MINI_W-1:0]   min_int_reg;

    logic signed [SUM_W-1:0] sum_reg;
    logic [SSQ_W-1:0]        sumsq_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [D_W-1:0]          dx_reg, dy_reg, dz_reg;

    logic ev_reg, soon_reg, eval_reg;
    logic out_valid_reg, out_event_reg, out_soon_reg, out_eval_reg;

    logic              in_ready;
    logic              accept;
    logic              full;
    logic [SQ_W-1:0]   sq_op;
    logic [PROD_W-1:0] sq;
    logic              out_free;

    triple_t                 entry;
    sample_t                 v;
    logic [SAMPLE_BITS-1:0]  v_mag;
    logic [SUM_W-1:0]        sum_abs;
    logic [D_W-1:0]          d_new;
    logic [LIM_W-1:0]        lim;
    logic [TS_W-1:0]         elapsed;
    logic                    shake;

    assign accept   = sample.valid && in_ready;
    assign full     = (fill_reg == FILL_W'(WINDOW));
    assign out_free = !out_valid_reg || result.ready;

    assign entry = win_reg[idx_reg];

    always_comb
    begin
        case (axis_reg)
            AX_X:    v = entry.x;
            AX_Y:    v = entry.y;
            AX_Z:    v = entry.z;
            default: v = entry.x;
        endcase
    end

    assign v_mag   = v[SAMPLE_BITS-1] ? SAMPLE_BITS'(-v) : SAMPLE_BITS'(v);
    assign sum_abs = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    // shared squarer
    assign sq = PROD_W'(sq_op) * PROD_W'(sq_op);

    // n*sum(v^2) - (sum v)^2, wraps harmlessly as the true value fits
    assign d_new = D_W'(sumsq_reg) * D_W'(WINDOW) - D_W'(prod_reg);

    assign lim     = LIM_W'(prod_reg[2*THR_W-1:0]) * LIM_W'(WINDOW * WINDOW);
    assign elapsed = ts_reg - last_shake_reg;
    assign shake   = (CMP_W'(dx_reg) > CMP_W'(lim))
                  && (CMP_W'(dx_reg) > (CMP_W'(dy_reg) << 2))
                  && (CMP_W'(dx_reg) > (CMP_W'(dz_reg) << 2));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = full ? ST_ACC : ST_DONE;
            end
            ST_ACC:
            begin
                if (idx_reg == IDX_W'(WINDOW - 1))
                    state_next = ST_SQS;
            end
            ST_SQS: state_next = ST_DIF;
            ST_DIF: state_next = (axis_reg == AX_Z) ? ST_THR : ST_ACC;
            ST_THR: state_next = ST_CMP;
            ST_CMP: state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready = 1'b0;
        sq_op    = '0;
        case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_ACC:  sq_op = SQ_W'(v_mag);
            ST_SQS:  sq_op = SQ_W'(sum_abs[MAG_W-1:0]);
            ST_THR:  sq_op = SQ_W'(thr_reg);
            default: sq_op = '0;
        endcase
    end

    assign sample.ready            = in_ready;
    assign result.valid            = out_valid_reg;
    assign result.shake_event      = out_event_reg;
    assign result.shake_too_soon   = out_soon_reg;
    assign result.window_evaluated = out_eval_reg;

    // control and status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            oldest_reg     <= '0;
            idx_reg        <= '0;
            axis_reg       <= AX_X;
            last_shake_reg <= '0;
            thr_reg        <= THR_W'(1280);
            min_int_reg    <= MINI_W'(2000000);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SD_THRESHOLD: thr_reg     <= cfg_data[THR_W-1:0];
                    REG_MIN_INTERVAL: min_int_reg <= cfg_data[MINI_W-1:0];
                    default: ;
                endcase
            end

            // a new word enters the result register as the old one leaves
            if ((state_reg == ST_DONE) && out_free)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        idx_reg  <= '0;
                        axis_reg <= AX_X;
                        if (full)
                            oldest_reg <= (oldest_reg == IDX_W'(WINDOW - 1))
                                        ? '0 : oldest_reg + 1'b1;
                        else
                            fill_reg <= fill_reg + 1'b1;
                    end
                end
                ST_ACC:
                begin
                    if (idx_reg != IDX_W'(WINDOW - 1))
                        idx_reg <= idx_reg + 1'b1;
                end
                ST_DIF:
                begin
                    idx_reg <= '0;
                    case (axis_reg)
                        AX_X:    axis_reg <= AX_Y;
                        AX_Y:    axis_reg <= AX_Z;
                        default: axis_reg <= AX_X;
                    endcase
                end
                ST_CMP:
                begin
                    if (shake)
                    begin
                        fill_reg   <= '0;
                        oldest_reg <= '0;
                        if (elapsed > TS_W'(min_int_reg))
                            last_shake_reg <= ts_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (full)
                        win_reg[oldest_reg] <= '{to_sample(sample.accel_x),
                                                 to_sample(sample.accel_y),
                                                 to_sample(sample.accel_z)};
                    else
                        win_reg[fill_reg[IDX_W-1:0]] <= '{to_sample(sample.accel_x),
                                                          to_sample(sample.accel_y),
                                                          to_sample(sample.accel_z)};
                    ts_reg    <= sample.timestamp_us;
                    sum_reg   <= '0;
                    sumsq_reg <= '0;
                    ev_reg    <= 1'b0;
                    soon_reg  <= 1'b0;
                    eval_reg  <= 1'b0;
                end
            end
            ST_ACC:
            begin
                sum_reg  <= sum_reg + SUM_W'(v);
                prod_reg <= sq;
                // square of the previous entry is registered and added in the following cycle
                if (idx_reg != '0)
                    sumsq_reg <= sumsq_reg + SSQ_W'(prod_reg[2*SAMPLE_BITS-1:0]);
            end
            ST_SQS:
            begin
                sumsq_reg <= sumsq_reg + SSQ_W'(prod_reg[2*SAMPLE_BITS-1:0]);
                prod_reg  <= sq;
            end
            ST_DIF:
            begin
                case (axis_reg)
                    AX_X:    dx_reg <= d_new;
                    AX_Y:    dy_reg <= d_new;
                    default: dz_reg <= d_new;
                endcase
                sum_reg   <= '0;
                sumsq_reg <= '0;
            end
            ST_THR:
            begin
                prod_reg <= sq;
            end
            ST_CMP:
            begin
                eval_reg <= 1'b1;
                if (shake)
                begin
                    if (elapsed > TS_W'(min_int_reg))
                        ev_reg <= 1'b1;
                    else
                        soon_reg <= 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_event_reg <= ev_reg;
                    out_soon_reg  <= soon_reg;
                    out_eval_reg  <= eval_reg;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// File: dv/tb.sv
// testbench for the shake detector: random sample stream, flag predictor and result checker
`default_nettype none

module tb
    import shkd_pkg::*;
;

    localparam int QUIET_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 80;

    typedef struct packed {
        sample_t         x;
        sample_t         y;
        sample_t         z;
        logic [TS_W-1:0] ts;
    } accel_word_t;

    typedef struct packed {
        logic evt;
        logic soon;
        logic evald;
    } shake_flags_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    shkd_sample_if sample_ch();
    shkd_result_if result_ch();

    shake_detector_windowed_variance_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    accel_word_t  pending_words[$];
    shake_flags_t flags_due[$];

    // predictor state
    sample_t          hist_x[WINDOW];
    sample_t          hist_y[WINDOW];
    sample_t          hist_z[WINDOW];
    int               held;
    int               oldest;
    logic [TS_W-1:0]  last_shake_us;
    logic [THR_W-1:0] thr_cfg;
    logic [MINI_W-1:0] gap_cfg;

    logic [TS_W-1:0] clock_us;
    logic word_taken;
    logic calm;
    int   words_in;
    int   phase_words;
    int   n_tested;
    int   n_shakes;
    int   n_soon;
    int   errors;
    int   quiet;

    assign calm = (words_in >= 400) && (words_in < 600);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // stores the sample, and once full runs the variance tests on the updated windows
    function automatic shake_flags_t judge_sample(accel_word_t w);
        shake_flags_t f;
        longint sx, sy, sz, qx, qy, qz, dx, dy, dz, lim;
        logic [TS_W-1:0] since;
        f = '0;
        if (held == WINDOW)
        begin
            hist_x[oldest] = w.x;
            hist_y[oldest] = w.y;
            hist_z[oldest] = w.z;
            oldest = (oldest == WINDOW - 1) ? 0 : oldest + 1;
            f.evald = 1'b1;
            sx = 0; sy = 0; sz = 0; qx = 0; qy = 0; qz = 0;
            for (int i = 0; i < WINDOW; i++)
            begin
                sx += longint'(hist_x[i]);
                sy += longint'(hist_y[i]);
                sz += longint'(hist_z[i]);
                qx += longint'(hist_x[i]) * longint'(hist_x[i]);
                qy += longint'(hist_y[i]) * longint'(hist_y[i]);
                qz += longint'(hist_z[i]) * longint'(hist_z[i]);
            end
            dx = WINDOW * qx - sx * sx;
            dy = WINDOW * qy - sy * sy;
            dz = WINDOW * qz - sz * sz;
            lim = longint'(WINDOW * WINDOW) * longint'(thr_cfg) * longint'(thr_cfg);
            if (dx > lim && dx > 4 * dy && dx > 4 * dz)
            begin
                since = w.ts - last_shake_us;
                if (since > {16'd0, gap_cfg})
                begin
                    f.evt = 1'b1;
                    last_shake_us = w.ts;
                end
                else
                begin
                    f.soon = 1'b1;
                end
                held = 0;
                oldest = 0;
            end
        end
        else
        begin
            hist_x[held] = w.x;
            hist_y[held] = w.y;
            hist_z[held] = w.z;
            held++;
        end
        return f;
    endfunction

    // driver: presents queued samples, holds each until taken
    always @(negedge clk)
    begin : sample_driver
        accel_word_t w;
        if (rst_n && (!sample_ch.valid || word_taken))
        begin
            if (pending_words.size() != 0 && (calm || $urandom_range(0, 99) >= 33))
            begin
                w = pending_words.pop_front();
                sample_ch.valid        <= 1'b1;
                sample_ch.accel_x      <= w.x;
                sample_ch.accel_y      <= w.y;
                sample_ch.accel_z      <= w.z;
                sample_ch.timestamp_us <= w.ts;
            end
            else
            begin
                sample_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        result_ch.ready <= calm || ($urandom_range(0, 99) >= 33);
    end

    // taken samples go through the predictor; watchdog on handshake activity
    always @(posedge clk)
    begin : sample_capture
        shake_flags_t f;
        if (rst_n)
        begin
            word_taken = sample_ch.valid && sample_ch.ready;
            if (word_taken)
            begin
                f = judge_sample({sample_ch.accel_x, sample_ch.accel_y, sample_ch.accel_z,
                                  sample_ch.timestamp_us});
                flags_due.push_back(f);
                words_in++;
                n_tested += f.evald;
                n_shakes += f.evt;
                n_soon   += f.soon;
            end
            if (word_taken || (result_ch.valid && result_ch.ready) || cfg_we)
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
                $display("** shake_detector_windowed_variance_core: FAILED **");
                $finish;
            end
        end
    end

    // monitor: each result word against the oldest prediction
    always @(posedge clk)
    begin : result_monitor
        shake_flags_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (flags_due.size() == 0)
            begin
                $error("result word with no sample waiting for it");
                errors++;
            end
            else
            begin
                want = flags_due.pop_front();
                if (result_ch.shake_event !== want.evt)
                begin
                    $error("shake_event: expected %0b, got %0b", want.evt,
                           result_ch.shake_event);
                    errors++;
                end
                if (result_ch.shake_too_soon !== want.soon)
                begin
                    $error("shake_too_soon: expected %0b, got %0b", want.soon,
                           result_ch.shake_too_soon);
                    errors++;
                end
                if (result_ch.window_evaluated !== want.evald)
                begin
                    $error("window_evaluated: expected %0b, got %0b", want.evald,
                           result_ch.window_evaluated);
                    errors++;
                end
            end
        end
    end

    // queue one sample; a negative step means a random timestamp step: advance, repeat or jump
    task automatic add_word(input int x, input int y, input int z, input longint step);
        accel_word_t w;
        int r;
        if (step >= 0)
        begin
            clock_us += TS_W'(step);
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
                clock_us += TS_W'($urandom_range(9000, 11000));
            else if (r < 94 && r >= 88)
                clock_us += {16'd0, 32'($urandom)};
            else if (r >= 94)
                clock_us = {16'($urandom), 32'($urandom)};
            // remaining cases repeat the previous stamp
        end
        w.x  = sample_t'(x);
        w.y  = sample_t'(y);
        w.z  = sample_t'(z);
        w.ts = clock_us;
        pending_words.push_back(w);
        phase_words++;
    endtask

    // x swings around its extremes, y and z carry bounded noise
    task automatic shake_burst(input int amp);
        int len, jit, side, j;
        len  = $urandom_range(16, 26);
        jit  = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, amp / 8);
        side = $urandom_range(0, amp);
        for (int i = 0; i < len; i++)
        begin
            j = $urandom_range(0, jit);
            add_word(i[0] ? amp - j : -amp - 1 + j,
                     int'($urandom_range(0, 2 * side)) - side,
                     int'($urandom_range(0, 2 * side)) - side, -1);
        end
    endtask

    task automatic calm_run();
        int len;
        len = $urandom_range(1, 30);
        for (int i = 0; i < len; i++)
            add_word(int'($urandom_range(0, 600)) - 300, int'($urandom_range(0, 600)) - 300,
                     int'($urandom_range(0, 600)) - 300, -1);
    endtask

    task automatic noise_run();
        int len;
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++)
            add_word(int'(16'($urandom)), int'(16'($urandom)), int'(16'($urandom)), -1);
    endtask

    task automatic run_phase(input int count, input int amp_lo, input int amp_hi);
        int r;
        phase_words = 0;
        while (phase_words < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                shake_burst($urandom_range(amp_lo, amp_hi));
            else if (r < 80)
                calm_run();
            else
                noise_run();
        end
    endtask

    // wait until nothing is in flight, then let the sequencer wind down
    task automatic settle();
        while (pending_words.size() != 0 || flags_due.size() != 0 || sample_ch.valid)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == REG_SD_THRESHOLD)
            thr_cfg = data[THR_W-1:0];
        else
            gap_cfg = data[MINI_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = '0;
        cfg_data               = '0;
        sample_ch.valid        = 1'b0;
        sample_ch.accel_x      = '0;
        sample_ch.accel_y      = '0;
        sample_ch.accel_z      = '0;
        sample_ch.timestamp_us = '0;
        result_ch.ready        = 1'b0;
        word_taken             = 1'b0;
        words_in               = 0;
        phase_words            = 0;
        n_tested               = 0;
        n_shakes               = 0;
        n_soon                 = 0;
        errors                 = 0;
        quiet                  = 0;
        held                   = 0;
        oldest                 = 0;
        last_shake_us          = '0;
        thr_cfg                = THR_W'(1280);
        gap_cfg                = MINI_W'(2000000);
        clock_us               = TS_W'(5000000);
        for (int i = 0; i < WINDOW; i++)
        begin
            hist_x[i] = '0;
            hist_y[i] = '0;
            hist_z[i] = '0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // full-scale x swing fills the windows and shakes on the first test
        for (int i = 0; i < 21; i++)
            add_word(i[0] ? 32767 : -32768, i[0] ? 1 : -1, 0, 10000);
        add_word(0, 32767, -32768, 10000);
        add_word(-1, -32768, 32767, 10000);
        add_word(32767, 0, -1, 10000);
        add_word(-32768, -1, 0, 10000);
        run_phase(220, 600, 6000);

        // zero threshold, zero interval: any dominant x spread shakes
        settle();
        write_reg(REG_SD_THRESHOLD, '0);
        write_reg(REG_MIN_INTERVAL, '0);
        run_phase(240, 0, 4000);

        // both registers at their top
        settle();
        write_reg(REG_SD_THRESHOLD, CFG_W'(32767));
        write_reg(REG_MIN_INTERVAL, 32'hFFFF_FFFF);
        run_phase(240, 32767, 32767);

        settle();
        write_reg(REG_SD_THRESHOLD, CFG_W'($urandom_range(200, 4000)));
        write_reg(REG_MIN_INTERVAL, CFG_W'($urandom_range(20000, 600000)));
        run_phase(240, 300, 12000);

        // reset values again, timestamps running through the wrap
        settle();
        write_reg(REG_SD_THRESHOLD, CFG_W'(1280));
        write_reg(REG_MIN_INTERVAL, CFG_W'(2000000));
        clock_us = 48'hFFFF_FFF0_0000;
        run_phase(240, 600, 6000);

        settle();
        if (flags_due.size() != 0)
        begin
            $error("%0d result words never arrived", flags_due.size());
            errors++;
        end
        $display("run: %0d samples, %0d window tests, %0d shakes reported, %0d too soon",
                 words_in, n_tested, n_shakes, n_soon);
        $display("thresholds 0 to 32767, intervals 0 to 2^32-1, timestamp jumps and wrap");
        if (errors == 0)
            $display("** shake_detector_windowed_variance_core: PASSED **");
        else
            $display("** shake_detector_windowed_variance_core: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
src/shkd_pkg.sv
src/shkd_sample_if.sv
src/shkd_result_if.sv
src/shake_detector_windowed_variance_core.sv
dv/tb.sv
